>>> rtl/wls_pkg.sv
`timescale 1ns / 1ps
// Shared constants and controller/datapath handshake types for the
// windowed latency statistics block. No dependencies.
package wls_pkg;

	localparam int WINDOW  = 64;
	localparam int LAT_W   = 24;
	localparam int BYTES_W = 32;
	localparam int TOTAL_W = 48;
	localparam int COUNT_W = 7;
	localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W   = $clog2(WINDOW + 1);
	localparam int SUM_W   = LAT_W + SLOT_W;
	localparam int ITER_W  = $clog2(SUM_W + 1);

	typedef enum logic {
		PH_MEAN,
		PH_DEV
	} wls_phase_t;

	typedef struct packed {
		logic       pass_start;
		logic       div_start;
		logic       out_load;
		wls_phase_t phase;
	} wls_cmd_t;

	typedef struct packed {
		logic pass_done;
		logic div_done;
		logic out_free;
	} wls_sts_t;

endpackage

>>> rtl/wls_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for sample items and statistics items.
// Depends on wls_pkg for field widths.
interface wls_sample_if;
	logic                        valid;
	logic                        ready;
	logic [wls_pkg::LAT_W-1:0]   latency;
	logic [wls_pkg::BYTES_W-1:0] tx_bytes;
	logic [wls_pkg::BYTES_W-1:0] rx_bytes;

	modport source (output valid, latency, tx_bytes, rx_bytes, input ready);
	modport sink (input valid, latency, tx_bytes, rx_bytes, output ready);
endinterface

interface wls_stats_if;
	logic                        valid;
	logic                        ready;
	logic [wls_pkg::LAT_W-1:0]   mean_latency;
	logic [wls_pkg::LAT_W-1:0]   lowest_latency;
	logic [wls_pkg::LAT_W-1:0]   highest_latency;
	logic [wls_pkg::LAT_W-1:0]   jitter;
	logic [wls_pkg::COUNT_W-1:0] sample_count;
	logic [wls_pkg::TOTAL_W-1:0] byte_total;

	modport source (output valid, mean_latency, lowest_latency, highest_latency, jitter,
		sample_count, byte_total, input ready);
	modport sink (input valid, mean_latency, lowest_latency, highest_latency, jitter,
		sample_count, byte_total, output ready);
endinterface

>>> rtl/wls_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, shared by mean and jitter.
// Depends on wls_pkg.
module wls_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [wls_pkg::SUM_W-1:0] dividend,
	input  logic [wls_pkg::CNT_W-1:0] divisor,
	output logic                      done,
	output logic [wls_pkg::SUM_W-1:0] quotient
);
	import wls_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [ITER_W-1:0] iter_q;
	logic [CNT_W-1:0]  rem_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W:0]    shifted;
	logic [CNT_W:0]    diff;
	logic              fits;

	assign shifted = {rem_q, quo_q[SUM_W-1]};
	assign fits    = shifted >= {1'b0, divisor};
	assign diff    = shifted - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= ITER_W'(SUM_W);
			end else if (busy_q) begin
				iter_q <= iter_q - ITER_W'(1);
				if (iter_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

>>> rtl/wls_dp.sv
`timescale 1ns / 1ps
// Datapath: latency ring memory, window counters, byte total, scan
// accumulators, shared divider and output register. Depends on wls_pkg, wls_div.
module wls_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic [wls_pkg::LAT_W-1:0]   latency,
	input  logic [wls_pkg::BYTES_W-1:0] tx_bytes,
	input  logic [wls_pkg::BYTES_W-1:0] rx_bytes,
	input  wls_pkg::wls_cmd_t           cmd,
	output wls_pkg::wls_sts_t           sts,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [wls_pkg::LAT_W-1:0]   mean_latency,
	output logic [wls_pkg::LAT_W-1:0]   lowest_latency,
	output logic [wls_pkg::LAT_W-1:0]   highest_latency,
	output logic [wls_pkg::LAT_W-1:0]   jitter,
	output logic [wls_pkg::COUNT_W-1:0] sample_count,
	output logic [wls_pkg::TOTAL_W-1:0] byte_total
);
	import wls_pkg::*;

	logic [LAT_W-1:0]   ring_mem [WINDOW];
	logic [SLOT_W-1:0]  wslot_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [TOTAL_W-1:0] bytes_q;
	logic [TOTAL_W:0]   bytes_sum;

	logic               rd_act_q;
	logic [SLOT_W-1:0]  rd_idx_q;
	logic               rd_last;
	logic               rd_vld_s1;
	logic               rd_last_s1;
	logic [LAT_W-1:0]   rd_data_s1;

	logic [SUM_W-1:0]   sum_q;
	logic [SUM_W-1:0]   dev_q;
	logic [LAT_W-1:0]   min_q;
	logic [LAT_W-1:0]   max_q;
	logic [LAT_W-1:0]   mean_q;
	logic [LAT_W-1:0]   absdev;

	logic               div_done;
	logic [SUM_W-1:0]   quotient;
	logic [SUM_W-1:0]   dividend;

	logic               out_valid_q;

	assign bytes_sum = {1'b0, bytes_q} + (TOTAL_W + 1)'(tx_bytes)
		+ (TOTAL_W + 1)'(rx_bytes);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wslot_q <= '0;
			cnt_q   <= '0;
			bytes_q <= '0;
		end else if (load) begin
			wslot_q <= (wslot_q == SLOT_W'(WINDOW - 1)) ? '0 : wslot_q + SLOT_W'(1);
			if (cnt_q != CNT_W'(WINDOW))
				cnt_q <= cnt_q + CNT_W'(1);
			bytes_q <= bytes_sum[TOTAL_W] ? '1 : bytes_sum[TOTAL_W-1:0];
		end
	end

	// Scan slots 0 .. count-1; the ring fills from slot 0, so these are the window.
	assign rd_last = rd_idx_q == SLOT_W'(cnt_q - CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_act_q   <= 1'b0;
			rd_idx_q   <= '0;
			rd_vld_s1  <= 1'b0;
			rd_last_s1 <= 1'b0;
		end else begin
			rd_vld_s1  <= rd_act_q;
			rd_last_s1 <= rd_act_q && rd_last;
			if (cmd.pass_start) begin
				rd_act_q <= 1'b1;
				rd_idx_q <= '0;
			end else if (rd_act_q) begin
				rd_idx_q <= rd_idx_q + SLOT_W'(1);
				if (rd_last)
					rd_act_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			ring_mem[wslot_q] <= latency;
		rd_data_s1 <= ring_mem[rd_idx_q];
	end

	assign absdev = (rd_data_s1 >= mean_q) ? rd_data_s1 - mean_q : mean_q - rd_data_s1;

	always_ff @(posedge clk) begin
		if (cmd.pass_start) begin
			if (cmd.phase == PH_MEAN) begin
				sum_q <= '0;
				min_q <= '1;
				max_q <= '0;
			end else begin
				dev_q <= '0;
			end
		end else if (rd_vld_s1) begin
			if (cmd.phase == PH_MEAN) begin
				sum_q <= sum_q + SUM_W'(rd_data_s1);
				if (rd_data_s1 < min_q)
					min_q <= rd_data_s1;
				if (rd_data_s1 > max_q)
					max_q <= rd_data_s1;
			end else begin
				dev_q <= dev_q + SUM_W'(absdev);
			end
		end
		if (div_done && cmd.phase == PH_MEAN)
			mean_q <= LAT_W'(quotient);
	end

	assign dividend = (cmd.phase == PH_MEAN) ? sum_q : dev_q;

	wls_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// Jitter is the last quotient; the divider holds it until the next item
	// starts, so load it with the rest of the result.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			mean_latency    <= mean_q;
			lowest_latency  <= min_q;
			highest_latency <= max_q;
			jitter          <= LAT_W'(quotient);
			sample_count    <= COUNT_W'(cnt_q);
			byte_total      <= bytes_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign sts.pass_done = rd_vld_s1 && rd_last_s1;
	assign sts.div_done  = div_done;
	assign sts.out_free  = !out_valid_q || out_ready;
endmodule

>>> rtl/wls_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences ring scans and divisions for one item at a time.
// Depends on wls_pkg.
module wls_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  wls_pkg::wls_sts_t sts,
	output wls_pkg::wls_cmd_t cmd,
	output logic              ready
);
	import wls_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIV_MEAN,
		ST_DEV,
		ST_DIV_DEV,
		ST_DONE
	} state_t;

	state_t   state_q;
	wls_cmd_t cmd_q;
	logic     ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q   <= '{pass_start: 1'b0, div_start: 1'b0, out_load: 1'b0, phase: PH_MEAN};
			ready_q <= 1'b1;
		end else begin
			cmd_q.pass_start <= 1'b0;
			cmd_q.div_start  <= 1'b0;
			cmd_q.out_load   <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ready_q          <= 1'b0;
						cmd_q.pass_start <= 1'b1;
						cmd_q.phase      <= PH_MEAN;
						state_q          <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (sts.pass_done) begin
						cmd_q.div_start <= 1'b1;
						state_q         <= ST_DIV_MEAN;
					end
				end
				ST_DIV_MEAN: begin
					if (sts.div_done) begin
						cmd_q.pass_start <= 1'b1;
						cmd_q.phase      <= PH_DEV;
						state_q          <= ST_DEV;
					end
				end
				ST_DEV: begin
					if (sts.pass_done) begin
						cmd_q.div_start <= 1'b1;
						state_q         <= ST_DIV_DEV;
					end
				end
				ST_DIV_DEV: begin
					if (sts.div_done)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (sts.out_free) begin
						cmd_q.out_load <= 1'b1;
						ready_q        <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cmd   = cmd_q;
	assign ready = ready_q;
endmodule

>>> rtl/windowed_latency_statistics.sv
`timescale 1ns / 1ps
// Windowed latency statistics: min, max, mean and jitter over the last
// WINDOW latency samples, plus a saturating byte total.
// Depends on wls_pkg, wls_if, wls_dp, wls_ctrl.
//
// Usage:
//   samples - sink channel; one item is a latency (1/16 ms) and the byte
//             counts sent and received in the interval.
//   stats   - source channel; one item per sample: mean, min, max and jitter
//             of the window, the sample count and the running byte total.
// Timing: one item at a time. Each item runs a scan of the ring memory (one
// read port, one entry a cycle), a division for the mean on the shared
// bit-serial divider, a second scan and a division for the jitter on the
// same divider.
// A finished result waits in the output register; the block takes the next
// sample as soon as the result is loaded there, even while stats is stalled.
// If stats still holds the previous result when a new one completes, the
// controller waits until that item is taken.
// Reset clears the window count, the write slot and the byte total; ring
// contents need no clearing because only written slots are scanned.
module windowed_latency_statistics (
	input logic         clk,
	input logic         arst_n,
	wls_sample_if.sink  samples,
	wls_stats_if.source stats
);
	import wls_pkg::*;

	wls_cmd_t cmd;
	wls_sts_t sts;
	logic     accept;

	// Take a sample only when the controller has returned to idle.
	assign accept = samples.valid && samples.ready;

	wls_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.sts    (sts),
		.cmd    (cmd),
		.ready  (samples.ready)
	);

	wls_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.load            (accept),
		.latency         (samples.latency),
		.tx_bytes        (samples.tx_bytes),
		.rx_bytes        (samples.rx_bytes),
		.cmd             (cmd),
		.sts             (sts),
		.out_ready       (stats.ready),
		.out_valid       (stats.valid),
		.mean_latency    (stats.mean_latency),
		.lowest_latency  (stats.lowest_latency),
		.highest_latency (stats.highest_latency),
		.jitter          (stats.jitter),
		.sample_count    (stats.sample_count),
		.byte_total      (stats.byte_total)
	);

	// One item in flight: acceptance drops ready until the result is stored.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !samples.ready)
		else $error("sample accepted while previous item still in work");

	// The mean of a window lies between its extremes.
	a_mean_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		stats.valid |-> (stats.lowest_latency <= stats.mean_latency)
			&& (stats.mean_latency <= stats.highest_latency))
		else $error("mean latency outside min/max range");

	// Mean absolute deviation never exceeds the spread of the window.
	a_jitter_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		stats.valid |-> stats.jitter <= stats.highest_latency - stats.lowest_latency)
		else $error("jitter larger than window spread");

	// A scan and a division never finish in the same cycle.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> !sts.pass_done)
		else $error("scan and divider active together");
endmodule
